// ===== src/tlbcr_pkg.sv =====
// shared types, constants and codes for the clock replacement tlb
`default_nettype none
package tlbcr_pkg;

  localparam int TLB_DEPTH = 64;
  localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TLB_DEPTH + 1);

  localparam int ADDR_W    = 30;
  localparam int PAGE_W    = 27;
  localparam int SLOT_W    = 6;
  localparam int TOTAL_W   = 32;
  localparam int ENT_CFG_W = 7;
  localparam int PD_W      = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;
  localparam int DIV_CNT_W = 4;

  localparam logic [PD_W-1:0] PD_MIN     = PD_W'(1);
  localparam logic [PD_W-1:0] PD_MAX     = PD_W'(8);
  localparam logic [PD_W-1:0] DEC_DIGITS = PD_W'(9);

  localparam logic [ENT_CFG_W-1:0] ENT_RESET = ENT_CFG_W'(64);
  localparam logic [PD_W-1:0]      PD_RESET  = PD_W'(4);

  // floor(x / 10) == (x * RECIP10) >> DIV_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
  localparam int          DIV_SHIFT = 35;
  localparam int          PROD_W    = ADDR_W + 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TLB_ENTRIES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_DIGITS = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_CMP,
    S_MISS,
    S_SWEEP_RD,
    S_SWEEP,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic search_start;
    logic rd_en;
    logic idx_inc;
    logic hit;
    logic fill;
    logic sweep_start;
    logic sweep_rd;
    logic sweep_step;
    logic victim;
    logic write;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic search_end;
    logic tag_match;
    logic full;
    logic ref_set;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== src/tlbcr_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module tlbcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/tlbcr_ctrl.sv =====
// controller state machine for lookup, fill and clock sweep
`default_nettype none
module tlbcr_ctrl import tlbcr_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DIV;
      S_DIV:      if (status.div_last) state_nxt = S_RD;
      S_RD:       state_nxt = status.search_end ? S_MISS : S_CMP;
      S_CMP:      state_nxt = status.tag_match ? S_DONE : S_RD;
      S_MISS:     state_nxt = status.full ? S_SWEEP_RD : S_WRITE;
      S_SWEEP_RD: state_nxt = S_SWEEP;
      S_SWEEP:    state_nxt = status.ref_set ? S_SWEEP_RD : S_WRITE;
      S_WRITE:    state_nxt = S_DONE;
      S_DONE:     if (status.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIV: begin
        cmd.div_step     = 1'b1;
        cmd.search_start = status.div_last;
      end
      S_RD: begin
        cmd.rd_en = !status.search_end;
      end
      S_CMP: begin
        cmd.hit     = status.tag_match;
        cmd.idx_inc = !status.tag_match;
      end
      S_MISS: begin
        cmd.fill        = !status.full;
        cmd.sweep_start = status.full;
      end
      S_SWEEP_RD: begin
        cmd.sweep_rd = 1'b1;
      end
      S_SWEEP: begin
        cmd.sweep_step = status.ref_set;
        cmd.victim     = !status.ref_set;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
      end
      S_DONE: begin
        cmd.publish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/tlbcr_dp.sv =====
// datapath: config, page divider, tag ram, reference bits, counters, result register
`default_nettype none
module tlbcr_dp import tlbcr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [ADDR_W-1:0]      in_address,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_hit,
  output logic [SLOT_W-1:0]           out_slot,
  output logic                        out_evicted_valid,
  output logic [PAGE_W-1:0]           out_evicted_page,
  output logic [PAGE_W-1:0]           out_page_number,
  output logic [TOTAL_W-1:0]          out_hit_total,
  output logic [TOTAL_W-1:0]          out_miss_total
);

  logic [ENT_CFG_W-1:0] tlb_entries_r;
  logic [PD_W-1:0]      page_digits_r;
  logic [ADDR_W-1:0]    quot_r, quot_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     filled_r, filled_nxt;
  logic [CNT_W-1:0]     hand_r, hand_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic                 hit_r, hit_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic [PAGE_W-1:0]    ev_page_r, ev_page_nxt;
  logic [TOTAL_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [TOTAL_W-1:0]   miss_cnt_r, miss_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]     n_act;
  logic [CNT_W-1:0]     searched;
  logic [PD_W-1:0]      pd_act;
  logic [PROD_W-1:0]    prod;
  logic [CNT_W-1:0]     idx_wrap;
  logic [CNT_W-1:0]     slot_wrap;
  logic [IDX_W-1:0]     idx_lo;
  logic [PAGE_W-1:0]    page;
  logic [PAGE_W-1:0]    ram_rdata;
  logic                 ref_we;
  logic [IDX_W-1:0]     ref_waddr;
  logic                 ref_wdata;
  logic                 ref_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_entries_r <= ENT_RESET;
      page_digits_r <= PD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TLB_ENTRIES) begin
        tlb_entries_r <= ENT_CFG_W'(cfg_wdata);
      end
      if (cfg_index == CFG_PAGE_DIGITS) begin
        page_digits_r <= PD_W'(cfg_wdata);
      end
    end
  end

  always_comb begin
    if (tlb_entries_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(tlb_entries_r) > TLB_DEPTH) begin
      n_act = CNT_W'(TLB_DEPTH);
    end else begin
      n_act = CNT_W'(tlb_entries_r);
    end
    if (page_digits_r < PD_MIN) begin
      pd_act = PD_MIN;
    end else if (page_digits_r > PD_MAX) begin
      pd_act = PD_MAX;
    end else begin
      pd_act = page_digits_r;
    end
  end

  assign searched  = (filled_r < n_act) ? filled_r : n_act;
  assign idx_lo    = idx_r[IDX_W-1:0];
  assign page      = quot_r[PAGE_W-1:0];
  assign prod      = PROD_W'(quot_r) * PROD_W'(RECIP10);
  assign idx_wrap  = ((idx_r + CNT_W'(1)) >= n_act) ? '0 : idx_r + CNT_W'(1);
  assign slot_wrap = ((CNT_W'(slot_r) + CNT_W'(1)) >= n_act) ? '0
                     : CNT_W'(slot_r) + CNT_W'(1);

  tlbcr_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (TLB_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (slot_r),
    .wdata (page),
    .re    (cmd.rd_en | cmd.sweep_rd),
    .raddr (idx_lo),
    .rdata (ram_rdata)
  );

  // reference bits: set on a hit or a load, cleared as the hand passes
  assign ref_we    = cmd.hit | cmd.sweep_step | cmd.write;
  assign ref_waddr = cmd.write ? slot_r : idx_lo;
  assign ref_wdata = !cmd.sweep_step;

  tlbcr_ram #(
    .WIDTH (1),
    .DEPTH (TLB_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .re    (cmd.sweep_rd),
    .raddr (idx_lo),
    .rdata (ref_rdata)
  );

  assign status.div_last   = (div_cnt_r == DIV_CNT_W'(1));
  assign status.search_end = (idx_r >= searched);
  assign status.tag_match  = (ram_rdata == page);
  assign status.full       = (filled_r >= n_act);
  assign status.ref_set    = ref_rdata;
  assign status.out_free   = !out_valid_r || out_ready;

  always_comb begin
    quot_nxt      = quot_r;
    div_cnt_nxt   = div_cnt_r;
    idx_nxt       = idx_r;
    filled_nxt    = filled_r;
    hand_nxt      = hand_r;
    slot_nxt      = slot_r;
    hit_nxt       = hit_r;
    ev_valid_nxt  = ev_valid_r;
    ev_page_nxt   = ev_page_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load) begin
      quot_nxt    = in_address;
      div_cnt_nxt = DIV_CNT_W'(DEC_DIGITS - pd_act);
    end
    if (cmd.div_step) begin
      quot_nxt    = ADDR_W'(prod >> DIV_SHIFT);
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
    end
    if (cmd.search_start) begin
      idx_nxt = '0;
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    if (cmd.hit) begin
      hit_nxt      = 1'b1;
      slot_nxt     = idx_lo;
      ev_valid_nxt = 1'b0;
      ev_page_nxt  = '0;
      if (hit_cnt_r != '1) begin
        hit_cnt_nxt = hit_cnt_r + TOTAL_W'(1);
      end
    end
    if (cmd.fill) begin
      slot_nxt     = filled_r[IDX_W-1:0];
      filled_nxt   = filled_r + CNT_W'(1);
      ev_valid_nxt = 1'b0;
      ev_page_nxt  = '0;
    end
    if (cmd.sweep_start) begin
      idx_nxt = (hand_r >= n_act) ? '0 : hand_r;
    end
    if (cmd.sweep_step) begin
      idx_nxt = idx_wrap;
    end
    if (cmd.victim) begin
      slot_nxt     = idx_lo;
      ev_valid_nxt = 1'b1;
      ev_page_nxt  = ram_rdata;
    end
    if (cmd.write) begin
      hit_nxt  = 1'b0;
      hand_nxt = slot_wrap;
      if (miss_cnt_r != '1) begin
        miss_cnt_nxt = miss_cnt_r + TOTAL_W'(1);
      end
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      hand_r      <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      filled_r    <= filled_nxt;
      hand_r      <= hand_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r     <= quot_nxt;
    div_cnt_r  <= div_cnt_nxt;
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    hit_r      <= hit_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_page_r  <= ev_page_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_hit           <= hit_r;
      out_slot          <= SLOT_W'(slot_r);
      out_evicted_valid <= ev_valid_r;
      out_evicted_page  <= ev_page_r;
      out_page_number   <= page;
      out_hit_total     <= hit_cnt_r;
      out_miss_total    <= miss_cnt_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== src/tlb_clock_replacement.sv =====
// top level of the fully associative tlb with clock replacement
// Each address is reduced to a page number by k = 9 - page_digits divide-by-ten
// steps (one per cycle, page_digits clamped to 1..8), then the filled entries in
// the active range are compared one at a time through the single read port of
// the tag ram. A hit ends there. A miss fills the next empty slot, or, when the
// table is full, the clock hand reads each slot's tag and reference bit, clearing
// set bits until it finds a clear one, whose page is evicted. At most one item
// is in work at a time. A finished result sits in an output register, so the
// next address is taken while it waits for out_ready. Reset clears the fill
// count, hand and totals; tags and reference bits live in rams and a slot is
// only read after its fill wrote both, so there is no clearing pass.
`default_nettype none
module tlb_clock_replacement import tlbcr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ADDR_W-1:0]      in_address,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_hit,
  output logic [SLOT_W-1:0]           out_slot,
  output logic                        out_evicted_valid,
  output logic [PAGE_W-1:0]           out_evicted_page,
  output logic [PAGE_W-1:0]           out_page_number,
  output logic [TOTAL_W-1:0]          out_hit_total,
  output logic [TOTAL_W-1:0]          out_miss_total
);

  cmd_t    cmd;
  status_t status;

  tlbcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tlbcr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_address        (in_address),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_page_number   (out_page_number),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total)
  );

endmodule
`default_nettype wire

// ===== src/tlbcr_checker.sv =====
// port level checks for the clock replacement tlb and their binding
`default_nettype none
module tlbcr_checker import tlbcr_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic                   out_hit,
  input wire logic [SLOT_W-1:0]      out_slot,
  input wire logic                   out_evicted_valid,
  input wire logic [PAGE_W-1:0]      out_evicted_page,
  input wire logic [PAGE_W-1:0]      out_page_number,
  input wire logic [TOTAL_W-1:0]     out_hit_total,
  input wire logic [TOTAL_W-1:0]     out_miss_total
);

  // a stalled result transfer holds its slot, page number and totals
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot)
      && $stable(out_page_number) && $stable(out_hit_total)
      && $stable(out_miss_total))
  else $error("result changed while stalled");

  // a hit never evicts
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evicted_valid)
  else $error("hit reported an eviction");

  // evicted page is zero unless an eviction happened
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
  else $error("evicted page set without eviction");

  // the matching total already counts this result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit ? (out_hit_total != '0) : (out_miss_total != '0)))
  else $error("total does not include this result");

endmodule

bind tlb_clock_replacement tlbcr_checker u_tlbcr_checker (.*);
`default_nettype wire

// ===== test/tb_tlb_clock_replacement.sv =====
// testbench for the clock replacement tlb: directed address table, then random traces per setting
module tb_tlb_clock_replacement;
  import tlbcr_pkg::*;

  localparam int              CYCLE_LIMIT     = 3_000_000;
  localparam int              TAIL_CYCLES     = 300;
  localparam int              HOLD_CYCLES     = 300;
  localparam int              PHASES          = 12;
  localparam int              ITEMS_PER_PHASE = 158;
  localparam int              HOLD_PHASE      = 5;
  localparam longint unsigned ADDR_SPAN       = 64'd1 << ADDR_W;
  localparam int PHASE_ENTRIES [PHASES] = '{1, 3, 64, 8, 127, 0, 17, 2, 40, 64, 5, 0};
  localparam int PHASE_DIGITS  [PHASES] = '{1, 8, 4, 0, 15, 6, 2, 9, 3, 5, 7, 0};

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                evicted_valid;
    logic [PAGE_W-1:0]   evicted_page;
    logic [PAGE_W-1:0]   page_number;
    logic [TOTAL_W-1:0]  hit_total;
    logic [TOTAL_W-1:0]  miss_total;
  } tlb_result_t;

  typedef enum logic [1:0] {ROW_ADDR, ROW_ENTRIES, ROW_DIGITS} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    longint unsigned value;
    bit              typed;
    tlb_result_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [ADDR_W-1:0] in_address;
  logic out_valid;
  logic out_ready;
  logic out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic out_evicted_valid;
  logic [PAGE_W-1:0] out_evicted_page;
  logic [PAGE_W-1:0] out_page_number;
  logic [TOTAL_W-1:0] out_hit_total;
  logic [TOTAL_W-1:0] out_miss_total;

  // predictor state
  logic [PAGE_W-1:0]    tag_page [TLB_DEPTH];
  bit                   chance_bit [TLB_DEPTH];
  int                   filled;
  int                   sweep_hand;
  logic [TOTAL_W-1:0]   hits_total;
  logic [TOTAL_W-1:0]   misses_total;
  logic [ENT_CFG_W-1:0] entries_cfg;
  logic [PD_W-1:0]      digits_cfg;

  tlb_result_t expected_q[$];
  stim_row_t   directed_rows[$];
  int unsigned page_pool[$];
  tlb_result_t typed_want;
  bit          typed_ready = 1'b0;
  bit          sender_idles = 1'b1;
  bit          sink_idles = 1'b1;
  bit          hold_request = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  int          items_sent = 0;
  int          hits_seen = 0;
  int          misses_seen = 0;
  int          evictions_seen = 0;

  tlb_clock_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_page_number   (out_page_number),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total)
  );

  always #1 clk = ~clk;

  function automatic int active_count(input logic [ENT_CFG_W-1:0] entries);
    if (entries == 0) return 1;
    if (entries > TLB_DEPTH) return TLB_DEPTH;
    return int'(entries);
  endfunction

  function automatic longint unsigned page_divisor(input logic [PD_W-1:0] digits);
    logic [PD_W-1:0] pd;
    longint unsigned d;
    pd = (digits < PD_MIN) ? PD_MIN : ((digits > PD_MAX) ? PD_MAX : digits);
    d = 1;
    repeat (int'(DEC_DIGITS - pd)) d = d * 10;
    return d;
  endfunction

  function automatic tlb_result_t tlb_lookup(input logic [ADDR_W-1:0] addr);
    tlb_result_t r;
    logic [PAGE_W-1:0] page;
    int n;
    int w;
    bit found;
    n = active_count(entries_cfg);
    page = PAGE_W'(longint'(addr) / page_divisor(digits_cfg));
    r = '0;
    r.page_number = page;
    found = 1'b0;
    for (int i = 0; i < filled && i < n; i++) begin
      if (!found && tag_page[i] == page) begin
        found = 1'b1;
        w = i;
      end
    end
    if (found) begin
      chance_bit[w] = 1'b1;
      r.hit = 1'b1;
      if (hits_total != '1) hits_total++;
    end else begin
      if (misses_total != '1) misses_total++;
      if (filled < n) begin
        w = filled;
        filled++;
      end else begin
        w = (sweep_hand >= n) ? 0 : sweep_hand;
        while (chance_bit[w]) begin
          chance_bit[w] = 1'b0;
          w = (w + 1 >= n) ? 0 : w + 1;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page = tag_page[w];
      end
      tag_page[w] = page;
      chance_bit[w] = 1'b1;
      sweep_hand = (w + 1 >= n) ? 0 : w + 1;
    end
    r.slot = SLOT_W'(w);
    r.hit_total = hits_total;
    r.miss_total = misses_total;
    return r;
  endfunction

  function automatic tlb_result_t outcome(input bit hit, input int slot, input bit ev_valid,
                                          input int ev_page, input int page,
                                          input int hit_tot, input int miss_tot);
    tlb_result_t r;
    r.hit = hit;
    r.slot = SLOT_W'(slot);
    r.evicted_valid = ev_valid;
    r.evicted_page = PAGE_W'(ev_page);
    r.page_number = PAGE_W'(page);
    r.hit_total = TOTAL_W'(hit_tot);
    r.miss_total = TOTAL_W'(miss_tot);
    return r;
  endfunction

  function automatic void add_row(input row_kind_t kind, input longint unsigned value,
                                  input bit typed = 1'b0, input tlb_result_t want = '0);
    stim_row_t row;
    row.kind = kind;
    row.value = value;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address(input longint unsigned div);
    longint unsigned lo;
    longint unsigned span;
    if ($urandom_range(0, 99) < 15 || page_pool.size() == 0) return ADDR_W'($urandom());
    lo = longint'(page_pool[$urandom_range(0, page_pool.size() - 1)]) * div;
    span = ADDR_SPAN - lo;
    if (span > div) span = div;
    return ADDR_W'(lo + $urandom_range(0, int'(span - 1)));
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // one address transfer, then the sender's gap before the next one
  task automatic send_address(input logic [ADDR_W-1:0] addr);
    int gap;
    in_valid <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    gap = sender_idles ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : monitor
    tlb_result_t want;
    tlb_result_t got;
    if (!rst_n) begin
      foreach (chance_bit[i]) chance_bit[i] = 1'b0;
      filled = 0;
      sweep_hand = 0;
      hits_total = '0;
      misses_total = '0;
      entries_cfg = ENT_RESET;
      digits_cfg = PD_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TLB_ENTRIES) entries_cfg = cfg_wdata[ENT_CFG_W-1:0];
        else if (cfg_index == CFG_PAGE_DIGITS) digits_cfg = cfg_wdata[PD_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no lookup outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("hit", want.hit, out_hit);
          check_field("slot", want.slot, out_slot);
          check_field("evicted_valid", want.evicted_valid, out_evicted_valid);
          check_field("evicted_page", want.evicted_page, out_evicted_page);
          check_field("page_number", want.page_number, out_page_number);
          check_field("hit_total", want.hit_total, out_hit_total);
          check_field("miss_total", want.miss_total, out_miss_total);
          if (want.hit) hits_seen++;
          else misses_seen++;
          if (want.evicted_valid) evictions_seen++;
        end
      end
      if (in_valid && in_ready) begin
        got = tlb_lookup(in_address);
        if (typed_ready) begin
          got = typed_want;
          typed_ready = 1'b0;
        end
        expected_q.push_back(got);
        items_sent++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_tlb_clock_replacement: FAIL");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = sink_idles ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int ent;
    int dig;
    int n;
    longint unsigned div;
    longint unsigned top_page;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_address = '0;

    // reset settings: 64 entries, page = address / 100000
    add_row(ROW_ADDR, 0,           1'b1, outcome(0, 0, 0, 0, 0,     0, 1));
    add_row(ROW_ADDR, 99999,       1'b1, outcome(1, 0, 0, 0, 0,     1, 1));
    add_row(ROW_ADDR, 999999999,   1'b1, outcome(0, 1, 0, 0, 9999,  1, 2));
    add_row(ROW_ADDR, 30'h3FFFFFFF, 1'b1, outcome(0, 2, 0, 0, 10737, 1, 3));
    add_row(ROW_ADDR, 100000,      1'b1, outcome(0, 3, 0, 0, 1,     1, 4));
    add_row(ROW_ADDR, 999900000,   1'b1, outcome(1, 1, 0, 0, 9999,  2, 4));
    add_row(ROW_ADDR, 30'h2AAAAAAA, 1'b1, outcome(0, 4, 0, 0, 7158,  2, 5));
    add_row(ROW_ADDR, 30'h15555555, 1'b1, outcome(0, 5, 0, 0, 3579,  2, 6));
    // shrink below the fill count, hand past the active range
    add_row(ROW_ENTRIES, 2);
    add_row(ROW_ADDR, 357900000);
    add_row(ROW_ADDR, 999999999);
    add_row(ROW_ADDR, 100000);
    add_row(ROW_ENTRIES, 0);
    add_row(ROW_ADDR, 200000);
    add_row(ROW_ADDR, 200001);
    add_row(ROW_ENTRIES, 127);
    add_row(ROW_DIGITS, 0);
    add_row(ROW_ADDR, 999999999);
    add_row(ROW_ADDR, 30'h3FFFFFFF);
    add_row(ROW_DIGITS, 15);
    add_row(ROW_ADDR, 30'h3FFFFFFF);
    add_row(ROW_DIGITS, 8);
    add_row(ROW_ADDR, 999999999);
    add_row(ROW_DIGITS, 9);
    add_row(ROW_ADDR, 5);
    add_row(ROW_DIGITS, 1);
    add_row(ROW_ENTRIES, 9);
    add_row(ROW_ADDR, 123456789);
    add_row(ROW_ADDR, 987654321);
    add_row(ROW_ADDR, 0);
    add_row(ROW_ADDR, 555555555);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_ADDR: begin
          typed_want = directed_rows[i].want;
          typed_ready = directed_rows[i].typed;
          send_address(ADDR_W'(directed_rows[i].value));
        end
        ROW_ENTRIES: begin
          drain();
          write_reg(CFG_TLB_ENTRIES, CFG_DATA_W'(directed_rows[i].value));
        end
        default: begin
          drain();
          write_reg(CFG_PAGE_DIGITS, CFG_DATA_W'(directed_rows[i].value));
        end
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      ent = (p == PHASES - 1) ? $urandom_range(0, 127) : PHASE_ENTRIES[p];
      dig = (p == PHASES - 1) ? $urandom_range(0, 15) : PHASE_DIGITS[p];
      write_reg(CFG_TLB_ENTRIES, CFG_DATA_W'(ent));
      write_reg(CFG_PAGE_DIGITS, CFG_DATA_W'(dig));
      n = active_count(ENT_CFG_W'(ent));
      div = page_divisor(PD_W'(dig));
      top_page = (ADDR_SPAN - 1) / div;
      // working set around the table size so hits and sweeps both show up
      page_pool.delete();
      repeat ($urandom_range(n / 2 + 1, 2 * n + 2))
        page_pool.push_back($urandom_range(0, int'(top_page)));
      sender_idles = !(p % 4 == 1 || p % 4 == 3);
      sink_idles = !(p % 4 == 2 || p % 4 == 3);
      if (p == HOLD_PHASE) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) send_address(pick_address(div));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d addresses over %0d random settings plus a directed table",
             items_sent, PHASES);
    $display("saw %0d hits, %0d misses, %0d evictions", hits_seen, misses_seen, evictions_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_tlb_clock_replacement: PASS");
    end else begin
      $display("tb_tlb_clock_replacement: FAIL");
    end
    $finish;
  end

endmodule
